FILE: rtl/u16c_pkg.sv
// ----------------------------------------------------------------------------
// u16c_pkg
// shared types, constants and the windows-1252 high block map for the
// utf-16le / windows-1252 decoder
// ----------------------------------------------------------------------------
package u16c_pkg;

	localparam int CP_W      = 21;
	localparam int OUT_DEPTH = 4;

	localparam logic [0:0] MODE_CP1252  = 1'b0;
	localparam logic [0:0] MODE_UTF16LE = 1'b1;

	// top six bits of a 16-bit unit for high and low surrogates
	localparam logic [5:0] SUR_HIGH_TAG = 6'b110110;
	localparam logic [5:0] SUR_LOW_TAG  = 6'b110111;

	localparam logic [CP_W-1:0] CP_INVALID = 21'h00FFFF;
	localparam logic [CP_W-1:0] SUPP_BASE  = 21'h010000;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            invalid;
		logic            run_end;
	} result_t;

	// results caused by one byte, count 0..2
	typedef struct packed {
		logic [1:0] n;
		result_t    res0;
		result_t    res1;
	} push_t;

	function automatic logic [CP_W-1:0] cp1252_map(input logic [7:0] b);
		logic [15:0] v;
		v = 16'h0000;
		if (b[7:5] == 3'b100) begin
			unique case (b[4:0])
				5'd0:  v = 16'h20ac;
				5'd1:  v = 16'h0081;
				5'd2:  v = 16'h201a;
				5'd3:  v = 16'h0192;
				5'd4:  v = 16'h201e;
				5'd5:  v = 16'h2026;
				5'd6:  v = 16'h2020;
				5'd7:  v = 16'h2021;
				5'd8:  v = 16'h02c6;
				5'd9:  v = 16'h2030;
				5'd10: v = 16'h0160;
				5'd11: v = 16'h2039;
				5'd12: v = 16'h0152;
				5'd13: v = 16'h008d;
				5'd14: v = 16'h017d;
				5'd15: v = 16'h008f;
				5'd16: v = 16'h0090;
				5'd17: v = 16'h2018;
				5'd18: v = 16'h2019;
				5'd19: v = 16'h201c;
				5'd20: v = 16'h201d;
				5'd21: v = 16'h2022;
				5'd22: v = 16'h2013;
				5'd23: v = 16'h2014;
				5'd24: v = 16'h02dc;
				5'd25: v = 16'h2122;
				5'd26: v = 16'h0161;
				5'd27: v = 16'h203a;
				5'd28: v = 16'h0153;
				5'd29: v = 16'h009d;
				5'd30: v = 16'h017e;
				5'd31: v = 16'h0178;
				default: v = 16'h0000;
			endcase
		end else begin
			v = {8'h00, b};
		end
		return {5'b00000, v};
	endfunction

endpackage

FILE: rtl/u16c_text_if.sv
// ----------------------------------------------------------------------------
// u16c_text_if
// byte channel into the decoder
// ----------------------------------------------------------------------------
interface u16c_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source (output valid, output data_byte, output end_of_text, input ready);
	modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

FILE: rtl/u16c_cp_if.sv
// ----------------------------------------------------------------------------
// u16c_cp_if
// code point channel out of the decoder
// ----------------------------------------------------------------------------
interface u16c_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        invalid;
	logic        run_end;

	modport source (output valid, output code_point, output invalid, output run_end,
		input ready);
	modport sink   (input valid, input code_point, input invalid, input run_end,
		output ready);
endinterface

FILE: rtl/u16c_cfg_if.sv
// ----------------------------------------------------------------------------
// u16c_cfg_if
// configuration write channel, one register
// ----------------------------------------------------------------------------
interface u16c_cfg_if;
	logic valid;
	logic ready;
	logic encoding_mode;

	modport source (output valid, output encoding_mode, input ready);
	modport sink   (input valid, input encoding_mode, output ready);
endinterface

FILE: rtl/u16c_decode.sv
// ----------------------------------------------------------------------------
// u16c_decode
// byte and surrogate holds, and the per-byte decode into up to two results
// ----------------------------------------------------------------------------
module u16c_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             mode,
	input  logic [7:0]       data_byte,
	input  logic             last,
	output u16c_pkg::push_t  push
);
	import u16c_pkg::*;

	logic [7:0]  low_q;
	logic        low_valid_q;
	logic [9:0]  lead_q;
	logic        lead_valid_q;

	logic [7:0]  low_d;
	logic        low_valid_d;
	logic [9:0]  lead_d;
	logic        lead_valid_d;

	logic [15:0]     unit;
	logic            is_high;
	logic            is_low;
	logic [CP_W-1:0] lead_cp;
	logic [CP_W-1:0] unit_cp;
	logic [CP_W-1:0] supp_cp;
	push_t           p;

	assign unit    = {data_byte, low_q};
	assign is_high = (unit[15:10] == SUR_HIGH_TAG);
	assign is_low  = (unit[15:10] == SUR_LOW_TAG);
	assign lead_cp = {5'b00000, SUR_HIGH_TAG, lead_q};
	assign unit_cp = {5'b00000, unit};
	assign supp_cp = SUPP_BASE + {1'b0, lead_q, unit[9:0]};

	always_comb begin
		p            = '0;
		low_d        = low_q;
		low_valid_d  = low_valid_q;
		lead_d       = lead_q;
		lead_valid_d = lead_valid_q;
		if (mode == MODE_CP1252) begin
			p.n               = 2'd1;
			p.res0.code_point = cp1252_map(data_byte);
			low_d             = '0;
			low_valid_d       = 1'b0;
			lead_d            = '0;
			lead_valid_d      = 1'b0;
		end else if (!low_valid_q) begin
			if (last) begin
				if (lead_valid_q) begin
					p.n               = 2'd2;
					p.res0.code_point = lead_cp;
					p.res1.code_point = CP_INVALID;
					p.res1.invalid    = 1'b1;
				end else begin
					p.n               = 2'd1;
					p.res0.code_point = CP_INVALID;
					p.res0.invalid    = 1'b1;
				end
				low_d        = '0;
				low_valid_d  = 1'b0;
				lead_d       = '0;
				lead_valid_d = 1'b0;
			end else begin
				low_d       = data_byte;
				low_valid_d = 1'b1;
			end
		end else begin
			low_d       = '0;
			low_valid_d = 1'b0;
			if (lead_valid_q && is_low) begin
				p.n               = 2'd1;
				p.res0.code_point = supp_cp;
				lead_d            = '0;
				lead_valid_d      = 1'b0;
			end else begin
				// a lone held high surrogate goes out first
				if (lead_valid_q) begin
					p.res0.code_point = lead_cp;
					p.res1.code_point = unit_cp;
				end else begin
					p.res0.code_point = unit_cp;
				end
				lead_d       = '0;
				lead_valid_d = 1'b0;
				if (is_high && !last) begin
					lead_d       = unit[9:0];
					lead_valid_d = 1'b1;
					p.n          = lead_valid_q ? 2'd1 : 2'd0;
				end else begin
					p.n = lead_valid_q ? 2'd2 : 2'd1;
				end
			end
			if (last) begin
				lead_d       = '0;
				lead_valid_d = 1'b0;
			end
		end
		p.res0.run_end = (p.n == 2'd1);
		p.res1.run_end = 1'b1;
	end

	assign push = fire ? p : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q        <= '0;
			low_valid_q  <= 1'b0;
			lead_q       <= '0;
			lead_valid_q <= 1'b0;
		end else if (fire) begin
			low_q        <= low_d;
			low_valid_q  <= low_valid_d;
			lead_q       <= lead_d;
			lead_valid_q <= lead_valid_d;
		end
	end

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last |=> !low_valid_q && !lead_valid_q)
		else $error("holds not cleared at end of text");

	a_cp1252_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (mode == MODE_CP1252) |=> !low_valid_q && !lead_valid_q)
		else $error("utf-16 hold left after single-byte decode");

endmodule

FILE: rtl/u16c_outbuf.sv
// ----------------------------------------------------------------------------
// u16c_outbuf
// result queue, takes up to two results a cycle and hands out one a beat
// ----------------------------------------------------------------------------
module u16c_outbuf #(
	parameter int DEPTH = u16c_pkg::OUT_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  u16c_pkg::push_t push,
	output logic            room,
	u16c_cp_if.source       cp_ch
);
	import u16c_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	result_t        mem [DEPTH];
	logic [PW-1:0]  head_q;
	logic [PW-1:0]  tail_q;
	logic [CW-1:0]  count_q;
	logic [PW-1:0]  tail_nx;
	logic           pop;
	result_t        head_res;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] ptr);
		return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign tail_nx  = nxt(tail_q);
	assign head_res = mem[head_q];
	assign pop      = cp_ch.valid && cp_ch.ready;

	// space for two more once this cycle's pop is counted
	assign room = (count_q <= CW'(DEPTH - 2)) || ((count_q == CW'(DEPTH - 1)) && pop);

	assign cp_ch.valid      = (count_q != '0);
	assign cp_ch.code_point = head_res.code_point;
	assign cp_ch.invalid    = head_res.invalid;
	assign cp_ch.run_end    = head_res.run_end;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[tail_q] <= push.res0;
		end
		if (push.n == 2'd2) begin
			mem[tail_nx] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= nxt(head_q);
			end
			if (push.n == 2'd1) begin
				tail_q <= tail_nx;
			end else if (push.n == 2'd2) begin
				tail_q <= nxt(tail_nx);
			end
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overflow");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (count_q + CW'(2) - CW'(pop) <= CW'(DEPTH)))
		else $error("two results pushed without space");

endmodule

FILE: rtl/utf16le_cp1252_decoder_core.sv
// ----------------------------------------------------------------------------
// utf16le_cp1252_decoder_core
// byte stream to unicode code points, windows-1252 or utf-16le
// ----------------------------------------------------------------------------
// path: a byte beat is registered in the input stage, then decoded into
// the result queue, from which its first result can be taken
// throughput: one byte a cycle while the queue has room for two; a byte that
// gives two results hands them out in turn; the queue sets the sustained rate
// reset: mode goes to windows-1252, all byte and surrogate holds clear,
// queue empties; nothing needs a clearing pass
// ----------------------------------------------------------------------------
module utf16le_cp1252_decoder_core #(
	parameter int OUT_DEPTH = u16c_pkg::OUT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	u16c_cfg_if.sink    cfg,
	u16c_text_if.sink   text_ch,
	u16c_cp_if.source   cp_ch
);
	import u16c_pkg::*;

	// configuration, for the user to write only while idle; the block does not enforce it
	logic mode_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	logic  adv;
	logic  room;
	push_t push;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CP1252;
		end else if (cfg.valid) begin
			mode_q <= cfg.encoding_mode;
		end
	end

	// the input stage moves on whenever the queue can take two results
	assign adv           = valid_s1 && room;
	assign text_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ch.ready) begin
			valid_s1 <= text_ch.valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (text_ch.valid && text_ch.ready) begin
			byte_s1 <= text_ch.data_byte;
			eot_s1  <= text_ch.end_of_text;
		end
	end

	// holds and per-byte decode
	u16c_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.mode      (mode_q),
		.data_byte (byte_s1),
		.last      (eot_s1),
		.push      (push)
	);

	// result queue in front of the output beat
	u16c_outbuf #(
		.DEPTH (OUT_DEPTH)
	) u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.cp_ch  (cp_ch)
	);

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(byte_s1) && $stable(eot_s1))
		else $error("input stage lost a stalled byte");

endmodule
